// File: src/divider_timer_with_reload_defines.svh
// Assertion macros for the timer modules (used by dtr_back).
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef DIVIDER_TIMER_WITH_RELOAD_DEFINES_SVH
`define DIVIDER_TIMER_WITH_RELOAD_DEFINES_SVH

// Same-cycle implication
`define DTR_CHECK_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DTR_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dtr_pkg.sv
`timescale 1ns / 1ps

package dtr_pkg;

    // Request codes on the input word
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Register selects
    localparam logic [1:0] SEL_DIV  = 2'd0;
    localparam logic [1:0] SEL_TIMA = 2'd1;
    localparam logic [1:0] SEL_TMA  = 2'd2;
    localparam logic [1:0] SEL_TAC  = 2'd3;

    // TAC rate selects, named by machine cycles per TIMA step
    localparam logic [1:0] TAC_RATE_M256 = 2'd0;
    localparam logic [1:0] TAC_RATE_M4   = 2'd1;
    localparam logic [1:0] TAC_RATE_M16  = 2'd2;
    localparam logic [1:0] TAC_RATE_M64  = 2'd3;

    localparam logic [15:0] DIV_RESET      = 16'h00CA;
    localparam logic [15:0] DIV_STEP       = 16'd4;
    localparam int          TAC_ENABLE_BIT = 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_TICK,
        OP_READ,
        OP_WRITE,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] sel;
        logic [7:0] data;
        logic [7:0] cycles;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Divider bit watched for each TAC rate select
    function automatic logic [3:0] watch_bit(input logic [1:0] rate_sel);
        logic [3:0] idx;
        begin
            unique case (rate_sel)
                TAC_RATE_M256: idx = 4'd9;
                TAC_RATE_M4:   idx = 4'd3;
                TAC_RATE_M16:  idx = 4'd5;
                default:       idx = 4'd7;
            endcase
            return idx;
        end
    endfunction

endpackage

// File: src/divider_timer_with_reload.sv
`timescale 1ns / 1ps

// Channel | Handshake            | Word
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_ready  | req_type, reg_select, write_data, cycle_count
// out     | out_valid / out_ready| read_data, timer_irq
//
// Reads, writes and no-ops go straight from the pop to the result register; a tick
// holds the execute unit through the pop, one clock per machine cycle, and the result.
// Decode stage and queue lie ahead of it: with nothing ahead, an accepted read passes
// the decode holding register, the queue and the result register in that order.
// Reset (rst_n low) sets DIV to 0x00CA and TIMA, TMA, TAC to zero.
// A stalled output holds the execute unit; input keeps filling the queue.
module divider_timer_with_reload
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [1:0] reg_select,
    input  logic [7:0] write_data,
    input  logic [7:0] cycle_count,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       timer_irq
);

    logic          push_valid;
    logic          push_ready;
    dtr_pkg::cmd_t push_cmd;
    logic          q_valid;
    logic          q_pop;
    dtr_pkg::cmd_t q_cmd;

    // Decode
    dtr_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .reg_select  (reg_select),
        .write_data  (write_data),
        .cycle_count (cycle_count),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    // Command queue
    dtr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    // Execute
    dtr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .pop       (q_pop),
        .q_cmd     (q_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .timer_irq (timer_irq)
    );

endmodule

// File: src/dtr_front.sv
`timescale 1ns / 1ps

// Accepts input words, decodes them into commands and holds one for the queue.
module dtr_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       req_type,
    input  logic [1:0]       reg_select,
    input  logic [7:0]       write_data,
    input  logic [7:0]       cycle_count,
    output logic             push_valid,
    input  logic             push_ready,
    output dtr_pkg::cmd_t    push_cmd
);

    dtr_pkg::cmd_t cmd_reg;
    dtr_pkg::cmd_t cmd_next;
    logic          valid_reg;
    logic          accept;

    assign in_ready   = !valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = valid_reg;
    assign push_cmd   = cmd_reg;

    // Decode: zero-cycle ticks and unknown requests become no-ops
    always_comb
    begin
        cmd_next.sel    = reg_select;
        cmd_next.data   = write_data;
        cmd_next.cycles = cycle_count;
        unique case (req_type)
            dtr_pkg::REQ_TICK:
                cmd_next.op = (cycle_count == 8'd0) ? dtr_pkg::OP_NOP : dtr_pkg::OP_TICK;
            dtr_pkg::REQ_READ:  cmd_next.op = dtr_pkg::OP_READ;
            dtr_pkg::REQ_WRITE: cmd_next.op = dtr_pkg::OP_WRITE;
            default:            cmd_next.op = dtr_pkg::OP_NOP;
        endcase
    end

    // Holding stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Holding stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// File: src/dtr_queue.sv
`timescale 1ns / 1ps

// Small command FIFO decoupling decode from execution.
module dtr_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  dtr_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop,
    output dtr_pkg::cmd_t pop_cmd
);

    dtr_pkg::cmd_t                    mem_reg [dtr_pkg::QUEUE_DEPTH];
    logic [dtr_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [dtr_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [dtr_pkg::QUEUE_CNT_W-1:0]  count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = (count_reg != dtr_pkg::QUEUE_CNT_W'(dtr_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == dtr_pkg::QUEUE_PTR_W'(dtr_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == dtr_pkg::QUEUE_PTR_W'(dtr_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/dtr_back.sv
`timescale 1ns / 1ps

`include "divider_timer_with_reload_defines.svh"

// Executes commands: register access straight from the pop, ticks one machine cycle per clock.
module dtr_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          pop,
    input  dtr_pkg::cmd_t q_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    read_data,
    output logic          timer_irq
);

    dtr_pkg::state_t state_reg;
    dtr_pkg::state_t state_next;

    logic [15:0] divider_reg;
    logic [7:0]  timer_count_reg;
    logic [7:0]  reload_value_reg;
    logic [7:0]  timer_control_reg;
    logic [7:0]  remaining_reg;
    logic        irq_acc_reg;
    logic        out_valid_reg;
    logic [7:0]  read_data_reg;
    logic        timer_irq_reg;

    logic        slot_free;
    logic        step_en;
    logic        finish;
    logic [15:0] div_inc;
    logic [3:0]  watch_idx;
    logic        fall_edge;
    logic [7:0]  tima_inc;
    logic [7:0]  reg_value;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign timer_irq = timer_irq_reg;

    // One machine cycle of the divider and the watched-bit edge
    assign div_inc   = divider_reg + dtr_pkg::DIV_STEP;
    assign watch_idx = dtr_pkg::watch_bit(timer_control_reg[1:0]);
    assign fall_edge = timer_control_reg[dtr_pkg::TAC_ENABLE_BIT]
                       && divider_reg[watch_idx] && !div_inc[watch_idx];
    assign tima_inc  = timer_count_reg + 8'd1;

    // Register read mux
    always_comb
    begin
        unique case (q_cmd.sel)
            dtr_pkg::SEL_DIV:  reg_value = divider_reg[15:8];
            dtr_pkg::SEL_TIMA: reg_value = timer_count_reg;
            dtr_pkg::SEL_TMA:  reg_value = reload_value_reg;
            default:           reg_value = timer_control_reg;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dtr_pkg::ST_IDLE:
            begin
                if (q_valid && slot_free && q_cmd.op == dtr_pkg::OP_TICK)
                begin
                    state_next = dtr_pkg::ST_RUN;
                end
            end
            dtr_pkg::ST_RUN:
            begin
                if (remaining_reg == 8'd0 && slot_free)
                begin
                    state_next = dtr_pkg::ST_IDLE;
                end
            end
            default: state_next = dtr_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        pop     = 1'b0;
        step_en = 1'b0;
        finish  = 1'b0;
        unique case (state_reg)
            dtr_pkg::ST_IDLE: pop = q_valid && slot_free;
            dtr_pkg::ST_RUN:
            begin
                step_en = (remaining_reg != 8'd0);
                finish  = (remaining_reg == 8'd0) && slot_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Timer state and tick bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg       <= dtr_pkg::DIV_RESET;
            timer_count_reg   <= 8'd0;
            reload_value_reg  <= 8'd0;
            timer_control_reg <= 8'd0;
            remaining_reg     <= 8'd0;
            irq_acc_reg       <= 1'b0;
        end
        else if (pop && q_cmd.op == dtr_pkg::OP_WRITE)
        begin
            unique case (q_cmd.sel)
                dtr_pkg::SEL_DIV:  divider_reg       <= 16'd0;
                dtr_pkg::SEL_TIMA: timer_count_reg   <= q_cmd.data;
                dtr_pkg::SEL_TMA:  reload_value_reg  <= q_cmd.data;
                default:           timer_control_reg <= q_cmd.data;
            endcase
        end
        else if (pop && q_cmd.op == dtr_pkg::OP_TICK)
        begin
            remaining_reg <= q_cmd.cycles;
            irq_acc_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            divider_reg   <= div_inc;
            remaining_reg <= remaining_reg - 8'd1;
            if (fall_edge)
            begin
                // wrap to zero reloads from TMA and flags the interrupt
                if (tima_inc == 8'd0)
                begin
                    timer_count_reg <= reload_value_reg;
                    irq_acc_reg     <= 1'b1;
                end
                else
                begin
                    timer_count_reg <= tima_inc;
                end
            end
        end
    end

    // Result word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((pop && q_cmd.op != dtr_pkg::OP_TICK) || finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result word payload
    always_ff @(posedge clk)
    begin
        if (pop && q_cmd.op != dtr_pkg::OP_TICK)
        begin
            read_data_reg <= (q_cmd.op == dtr_pkg::OP_READ) ? reg_value : 8'd0;
            timer_irq_reg <= 1'b0;
        end
        else if (finish)
        begin
            read_data_reg <= 8'd0;
            timer_irq_reg <= irq_acc_reg;
        end
    end

    `DTR_CHECK_SAME(a_irq_no_data, out_valid_reg && timer_irq_reg, read_data_reg == 8'd0, "irq word carries read data")
    `DTR_CHECK_NEXT(a_step_adds_four, step_en, divider_reg == $past(div_inc), "divider did not advance by one machine cycle")
    `DTR_CHECK_NEXT(a_idle_holds, state_reg == dtr_pkg::ST_IDLE && !q_valid, $stable(divider_reg) && $stable(timer_count_reg), "timer state moved with no command")
    `DTR_CHECK_SAME(a_run_no_pop, state_reg == dtr_pkg::ST_RUN, !pop, "command popped during a tick")

endmodule
